@@ design/stb_pkg.sv @@
// Shared types, constants and preset tables for the square-wave tone beeper.
package stb_pkg;

    // Request codes carried in the input word's tuser field.
    typedef enum logic [2:0] {
        REQ_PLAY_TONE   = 3'd0,
        REQ_PLAY_EFFECT = 3'd1,
        REQ_PLAY_TEST   = 3'd2,
        REQ_STOP        = 3'd3,
        REQ_TICK        = 3'd4
    } req_t;

    localparam int ReqWidth      = 3;
    localparam int FreqWidth     = 16;
    localparam int DurWidth      = 16;
    localparam int EffectWidth   = 8;
    localparam int AmpWidth      = 15;
    localparam int SampleWidth   = 16;
    localparam int PhaseWidth    = 32;
    localparam int CountWidth    = 21;
    localparam int FracWidth     = 15;

    localparam logic [AmpWidth-1:0] AmpReset = 15'd12000;

    // Default and preset tone settings.
    localparam logic [FreqWidth-1:0] DefaultFreqHz  = 16'd880;
    localparam logic [DurWidth-1:0]  DefaultDurMs   = 16'd1000;
    localparam logic [DurWidth-1:0]  UnknownDurMs   = 16'd120;
    localparam logic [DurWidth-1:0]  TestDurMs      = 16'd1200;

    // The phase step is freq * FullScale / SampleRateHz. It is split into an
    // integer multiple of freq and a fractional part that is found by a
    // reciprocal multiply, exact for every 16-bit frequency.
    localparam longint unsigned FullScale    = 64'hFFFF_FFFF;
    localparam longint unsigned SampleRateHz = 64'd16000;
    localparam int              FracShift    = 28;
    localparam int              IntMulWidth  = 19;
    localparam int              FracMulWidth = 27;
    localparam logic [IntMulWidth-1:0] IncIntMul = IntMulWidth'(FullScale / SampleRateHz);
    localparam logic [FracMulWidth-1:0] IncFracMul =
        FracMulWidth'((((FullScale % SampleRateHz) << FracShift) + SampleRateHz - 64'd1)
                      / SampleRateHz);

    // Values handed from the command setup logic to the playback stage.
    typedef struct packed {
        logic [PhaseWidth-1:0] inc_int;
        logic [FracWidth-1:0]  inc_frac;
        logic [CountWidth-1:0] count;
    } stb_setup_t;

    typedef struct packed {
        logic [FreqWidth-1:0] freq;
        logic [DurWidth-1:0]  dur;
    } tone_pair_t;

    // Preset sound effects; any unknown id plays the default pitch briefly.
    function automatic tone_pair_t effect_tone(input logic [EffectWidth-1:0] id);
        tone_pair_t pair;
        unique case (id)
            8'd0:    pair = '{freq: 16'd1000, dur: 16'd120};
            8'd1:    pair = '{freq: 16'd600,  dur: 16'd120};
            8'd2:    pair = '{freq: 16'd1400, dur: 16'd100};
            8'd3:    pair = '{freq: 16'd500,  dur: 16'd140};
            8'd4:    pair = '{freq: 16'd1200, dur: 16'd90};
            8'd5:    pair = '{freq: 16'd350,  dur: 16'd180};
            default: pair = '{freq: DefaultFreqHz, dur: UnknownDurMs};
        endcase
        return pair;
    endfunction

endpackage

@@ design/stb_tone_setup.sv @@
// Command decode: picks the tone for a play request and works out its phase step and length.
module stb_tone_setup
    import stb_pkg::*;
(
    input  logic [ReqWidth-1:0]    req,
    input  logic [FreqWidth-1:0]   freq_hz,
    input  logic [DurWidth-1:0]    dur_ms,
    input  logic [EffectWidth-1:0] effect_id,
    output stb_setup_t             setup
);

    tone_pair_t                          pair;
    logic [FreqWidth+IntMulWidth-1:0]    int_prod;
    logic [FreqWidth+FracMulWidth-1:0]   frac_prod;

    // Select the frequency and duration that the request plays.
    always_comb
    begin
        case (req)
            REQ_PLAY_EFFECT: pair = effect_tone(effect_id);
            REQ_PLAY_TEST:   pair = '{freq: DefaultFreqHz, dur: TestDurMs};
            default:
            begin
                pair.freq = (freq_hz == '0) ? DefaultFreqHz : freq_hz;
                pair.dur  = (dur_ms == '0) ? DefaultDurMs : dur_ms;
            end
        endcase
    end

    // Integer and fractional parts of the phase step; the sum is formed downstream.
    assign int_prod  = (FreqWidth+IntMulWidth)'(pair.freq)
                     * (FreqWidth+IntMulWidth)'(IncIntMul);
    assign frac_prod = (FreqWidth+FracMulWidth)'(pair.freq)
                     * (FreqWidth+FracMulWidth)'(IncFracMul);

    // Sixteen samples per millisecond at the fixed sample rate.
    assign setup.inc_int  = int_prod[PhaseWidth-1:0];
    assign setup.inc_frac = frac_prod[FracShift +: FracWidth];
    assign setup.count    = CountWidth'({pair.dur, 4'b0000});

endmodule

@@ design/square_tone_beeper_core.sv @@
// Top level of the square-wave tone beeper: stream ports, playback state and result register.
//
// The beeper takes one word per clock cycle while the result register is free or being
// taken, and returns exactly one result word for each. A word is loaded into the input
// register at the edge that accepts it, and its result word is loaded into the result
// register once that is free or being taken, raising m_tvalid. Play, stop and sample-tick
// requests may follow each other in consecutive cycles; the phase accumulator and sample
// counter close their update loop through the playback state registers. A result word that
// waits for m_tready holds the output while the next word still enters the input register.
// The tone amplitude register may be written only while no words are in flight.
module square_tone_beeper_core
    import stb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] tone_freq_hz, [31:16] tone_duration_ms, [39:32] effect_id
    input  logic [39:0]          s_tdata,
    // [2:0] req_type
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] sample_value, [16] playing, [23:17] zero
    output logic [23:0]          m_tdata,
    // [0] sample_valid
    output logic [0:0]           m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [AmpWidth-1:0]  cfg_wr_data
);

    stb_setup_t              setup;
    logic                    s1_valid_reg;
    logic [ReqWidth-1:0]     s1_req_reg;
    stb_setup_t              s1_setup_reg;
    logic                    advance;

    logic [AmpWidth-1:0]     amp_reg;
    logic                    tone_on_reg,   tone_on_next;
    logic [PhaseWidth-1:0]   phase_reg,     phase_next;
    logic [PhaseWidth-1:0]   inc_reg,       inc_next;
    logic [CountWidth-1:0]   samples_reg,   samples_next;

    logic                    m_tvalid_reg;
    logic [SampleWidth-1:0]  sample_reg,    sample_next;
    logic                    sample_valid_reg, sample_valid_next;
    logic                    playing_reg;
    logic [SampleWidth-1:0]  amp_ext;

    stb_tone_setup u_setup (
        .req       (s_tuser),
        .freq_hz   (s_tdata[15:0]),
        .dur_ms    (s_tdata[31:16]),
        .effect_id (s_tdata[39:32]),
        .setup     (setup)
    );

    // The input register moves on whenever the result register is free or being taken.
    assign advance  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_req_reg   <= s_tuser;
            s1_setup_reg <= setup;
        end
    end

    // Amplitude register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AmpReset;
        end
        else if (cfg_wr_en)
        begin
            amp_reg <= cfg_wr_data;
        end
    end

    assign amp_ext = SampleWidth'(amp_reg);

    // Playback step for the word in the input register.
    always_comb
    begin
        tone_on_next      = tone_on_reg;
        phase_next        = phase_reg;
        inc_next          = inc_reg;
        samples_next      = samples_reg;
        sample_next       = '0;
        sample_valid_next = 1'b0;
        unique case (s1_req_reg) inside
            REQ_PLAY_TONE, REQ_PLAY_EFFECT, REQ_PLAY_TEST:
            begin
                inc_next     = s1_setup_reg.inc_int + PhaseWidth'(s1_setup_reg.inc_frac);
                phase_next   = '0;
                samples_next = s1_setup_reg.count;
                tone_on_next = (s1_setup_reg.count != '0);
            end
            REQ_STOP:
            begin
                tone_on_next = 1'b0;
                phase_next   = '0;
                inc_next     = '0;
                samples_next = '0;
            end
            REQ_TICK:
            begin
                if (tone_on_reg && (samples_reg != '0))
                begin
                    phase_next        = phase_reg + inc_reg;
                    sample_next       = phase_next[PhaseWidth-1] ? amp_ext
                                                                 : SampleWidth'('0 - amp_ext);
                    sample_valid_next = 1'b1;
                    samples_next      = samples_reg - CountWidth'(1);
                    tone_on_next      = (samples_next != '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Playback state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_on_reg <= 1'b0;
            phase_reg   <= '0;
            inc_reg     <= '0;
            samples_reg <= '0;
        end
        else if (advance)
        begin
            tone_on_reg <= tone_on_next;
            phase_reg   <= phase_next;
            inc_reg     <= inc_next;
            samples_reg <= samples_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg       <= sample_next;
            sample_valid_reg <= sample_valid_next;
            playing_reg      <= tone_on_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, playing_reg, sample_reg};
    assign m_tuser  = sample_valid_reg;

endmodule
